>>> rtl/wndt_pkg.sv
package wndt_pkg;

    localparam int SLOT_W        = 4;
    localparam int COUNT_W       = 5;
    localparam int ID_W          = 31;
    localparam int DUR_W         = 48;
    localparam int CFG_W         = 5;
    localparam int MAX_SLOTS_DEF = 16;
    localparam int MAX_KEPT_RST  = 16;

    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef logic [DUR_W-1:0] t_dur;
    typedef logic [ID_W-1:0]  t_id;

endpackage

>>> rtl/worst_n_duration_tracker_top.sv
// sequence: decide, then output, when nothing is stored; decide, write,
// minimum rescan (one table read per slot) and output when the event is
// stored; the rescan runs through the single read port of the slot table
// and no new request is taken until the result has left the output state
// reset: synchronous, active low; count and minimum slot cleared, max_kept
// set to 16, table contents left as they are and never used before written
module worst_n_duration_tracker_top import wndt_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  t_id                i_event_id,
    input  t_dur               i_event_duration,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_taken,
    output logic [SLOT_W-1:0]  o_slot_written,
    output logic               o_evicted_valid,
    output t_id                o_evicted_id,
    output logic [COUNT_W-1:0] o_kept_count,
    output logic [SLOT_W-1:0]  o_min_slot,
    output t_dur               o_min_duration
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    logic [CFG_W-1:0] r_max_kept;
    logic [CNT_W-1:0] limit;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_dur             mem_wdur;
    t_id              mem_wid;
    logic [IDX_W-1:0] mem_raddr;
    t_dur             mem_rdur;
    t_id              mem_rid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_kept <= CFG_W'(MAX_KEPT_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_kept <= i_cfg_data;
        end
    end

    // limit saturates at the table depth
    assign limit = (int'(r_max_kept) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(r_max_kept);

    wndt_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_limit          (limit),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_event_id       (i_event_id),
        .i_event_duration (i_event_duration),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_taken          (o_taken),
        .o_slot_written   (o_slot_written),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_id     (o_evicted_id),
        .o_kept_count     (o_kept_count),
        .o_min_slot       (o_min_slot),
        .o_min_duration   (o_min_duration),
        .o_mem_we         (mem_we),
        .o_mem_waddr      (mem_waddr),
        .o_mem_wdur       (mem_wdur),
        .o_mem_wid        (mem_wid),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdur       (mem_rdur),
        .i_mem_rid        (mem_rid)
    );

    wndt_table #(
        .MAX_SLOTS (MAX_SLOTS),
        .IDX_W     (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdur  (mem_wdur),
        .i_wid   (mem_wid),
        .i_raddr (mem_raddr),
        .o_rdur  (mem_rdur),
        .o_rid   (mem_rid)
    );

endmodule

>>> rtl/wndt_table.sv
module wndt_table import wndt_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_dur             i_wdur,
    input  t_id              i_wid,
    input  logic [IDX_W-1:0] i_raddr,
    output t_dur             o_rdur,
    output t_id              o_rid
);

    t_dur r_dur [MAX_SLOTS];
    t_id  r_id  [MAX_SLOTS];
    t_dur r_q_dur;
    t_id  r_q_id;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_dur[i_waddr] <= i_wdur;
            r_id[i_waddr]  <= i_wid;
        end
        r_q_dur <= r_dur[i_raddr];
        r_q_id  <= r_id[i_raddr];
    end

    assign o_rdur = r_q_dur;
    assign o_rid  = r_q_id;

endmodule

>>> rtl/wndt_ctrl.sv
module wndt_ctrl import wndt_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CNT_W-1:0]   i_limit,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  t_id                i_event_id,
    input  t_dur               i_event_duration,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_taken,
    output logic [SLOT_W-1:0]  o_slot_written,
    output logic               o_evicted_valid,
    output t_id                o_evicted_id,
    output logic [COUNT_W-1:0] o_kept_count,
    output logic [SLOT_W-1:0]  o_min_slot,
    output t_dur               o_min_duration,
    output logic               o_mem_we,
    output logic [IDX_W-1:0]   o_mem_waddr,
    output t_dur               o_mem_wdur,
    output t_id                o_mem_wid,
    output logic [IDX_W-1:0]   o_mem_raddr,
    input  t_dur               i_mem_rdur,
    input  t_id                i_mem_rid
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_WRITE  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_short, n_short;
    t_dur             r_min_dur, n_min_dur;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_kind, n_kind;
    t_id              r_id, n_id;
    t_dur             r_dur, n_dur;
    logic             r_taken, n_taken;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic             r_evict, n_evict;
    t_id              r_ev_id, n_ev_id;

    logic             over;
    logic [CNT_W-1:0] cnt_eff;
    logic [IDX_W-1:0] sh_eff;
    logic             accept;
    logic [IDX_W-1:0] slot_sel;

    // a limit below the count empties the table before the offer
    assign over    = i_limit < r_count;
    assign cnt_eff = over ? '0 : r_count;
    assign sh_eff  = over ? '0 : r_short;
    assign accept  = (cnt_eff == '0) || (r_min_dur == '0) || (r_dur > r_min_dur);
    assign slot_sel = (cnt_eff < i_limit) ? cnt_eff[IDX_W-1:0] : sh_eff;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_short   = r_short;
        n_min_dur = r_min_dur;
        n_issue   = r_issue;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_kind    = r_kind;
        n_id      = r_id;
        n_dur     = r_dur;
        n_taken   = r_taken;
        n_slot    = r_slot;
        n_evict   = r_evict;
        n_ev_id   = r_ev_id;
        o_mem_we  = 1'b0;
        o_mem_raddr = sh_eff;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_id    = i_event_id;
                    n_dur   = i_event_duration;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // read of the minimum slot goes out here for a possible eviction
                n_taken = 1'b0;
                n_slot  = '0;
                n_evict = 1'b0;
                n_ev_id = '0;
                if (r_kind == KIND_CLEAR) begin
                    n_count = '0;
                    n_short = '0;
                    n_state = ST_OUT;
                end else if ((i_limit == '0) || !accept) begin
                    n_count = cnt_eff;
                    n_short = sh_eff;
                    n_state = ST_OUT;
                end else begin
                    n_taken = 1'b1;
                    n_slot  = slot_sel;
                    n_short = sh_eff;
                    if (cnt_eff < i_limit) begin
                        n_count = cnt_eff + CNT_W'(1);
                    end else begin
                        n_count = cnt_eff;
                        n_evict = 1'b1;
                    end
                    // running minimum starts at the current minimum slot
                    if (slot_sel == sh_eff) begin
                        n_min_dur = r_dur;
                    end
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_mem_we = 1'b1;
                if (r_evict) begin
                    n_ev_id = i_mem_rid;
                end
                n_issue   = '0;
                n_cmp_vld = 1'b0;
                n_state   = ST_SCAN;
            end
            ST_SCAN: begin
                o_mem_raddr = r_issue[IDX_W-1:0];
                if (r_issue < r_count) begin
                    n_issue   = r_issue + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_issue[IDX_W-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                // move only on a strictly shorter duration
                if (r_cmp_vld && (i_mem_rdur < r_min_dur)) begin
                    n_short   = r_cmp_idx;
                    n_min_dur = i_mem_rdur;
                end
                if (!r_cmp_vld && (r_issue == r_count)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_short   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_short   <= n_short;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_dur <= n_min_dur;
        r_issue   <= n_issue;
        r_cmp_idx <= n_cmp_idx;
        r_kind    <= n_kind;
        r_id      <= n_id;
        r_dur     <= n_dur;
        r_taken   <= n_taken;
        r_slot    <= n_slot;
        r_evict   <= n_evict;
        r_ev_id   <= n_ev_id;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

    assign o_mem_waddr = r_slot;
    assign o_mem_wdur  = r_dur;
    assign o_mem_wid   = r_id;

    assign o_taken         = r_taken;
    assign o_slot_written  = SLOT_W'(r_slot);
    assign o_evicted_valid = r_evict;
    assign o_evicted_id    = r_ev_id;
    assign o_kept_count    = COUNT_W'(r_count);
    assign o_min_slot      = (r_count != '0) ? SLOT_W'(r_short) : '0;
    assign o_min_duration  = (r_count != '0) ? r_min_dur : '0;

endmodule
